// ===== hdl/vgsr_pkg.sv =====
// vgsr_pkg: shared types, constants and the beat packing function of the
// grid scan remapper. No dependencies; every other file imports it.
package vgsr_pkg;

  // Opcodes of an input beat
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Three frame columns feed one grid; each page yields six shift bytes
  localparam int SLOTS          = 3;
  localparam int BYTES_PER_PAGE = 6;
  // Widest frame address over the allowed store sizes (16 pages x 256 columns)
  localparam int MEM_AW_MAX     = 12;

  typedef struct packed {
    logic       op;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] pixels;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [5:0] grid_number;
    logic       frame_start;
    logic       last;
  } out_item_t;

  // Frame memory port requests from the sequencer
  typedef struct packed {
    logic                  we;
    logic [MEM_AW_MAX-1:0] waddr;
    logic [7:0]            wdata;
    logic [MEM_AW_MAX-1:0] raddr;
  } mem_req_t;

  // Build shift byte idx of a page: pixel p = row*3 + slot, four pixels per
  // byte, on the even bit lanes for an even grid and the odd lanes otherwise.
  function automatic logic [7:0] pack_beat(input logic [SLOTS-1:0][7:0] src,
                                           input logic [2:0] idx,
                                           input logic odd);
    logic [23:0] pix;
    logic [3:0]  quad;
    logic [7:0]  beat;
    pix = '0;
    for (int row = 0; row < 8; row++) begin
      for (int slot = 0; slot < SLOTS; slot++) begin
        pix[row*SLOTS+slot] = src[slot][row];
      end
    end
    quad = pix[{idx, 2'b00} +: 4];
    beat = '0;
    for (int q = 0; q < 4; q++) begin
      beat[2*q]   = odd ? 1'b0 : quad[q];
      beat[2*q+1] = odd ? quad[q] : 1'b0;
    end
    return beat;
  endfunction

endpackage

// ===== hdl/vgsr_frame_mem.sv =====
// vgsr_frame_mem: frame store, one write port and one registered read port.
// Depends on vgsr_pkg for the port request struct.
module vgsr_frame_mem import vgsr_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write one byte per cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[req.raddr[ADDR_W-1:0]];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/vgsr_scan_seq.sv =====
// vgsr_scan_seq: sequencer that clears the store after reset, takes write
// and tick beats, fetches three columns per page and emits packed bytes.
// Depends on vgsr_pkg.
module vgsr_scan_seq import vgsr_pkg::*; #(
  parameter int GRID_COUNT   = 43,
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  output mem_req_t   mem_req,
  input  logic [7:0] mem_rd_data
);

  localparam int DEPTH  = PAGE_COUNT * COLUMN_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PG_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FETCH = 5'b00100,
    S_LAND  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ADDR_W-1:0]      clr_r, clr_nxt;
  logic [5:0]             grids_left_r, grids_left_nxt;
  logic [5:0]             grid_r, grid_nxt;
  logic                   start_r, start_nxt;
  logic [PG_W-1:0]        pg_r, pg_nxt;
  logic [1:0]             slot_r, slot_nxt;
  logic [2:0]             idx_r, idx_nxt;
  logic                   rd_valid_r, rd_valid_nxt;
  logic [1:0]             rd_slot_r, rd_slot_nxt;
  logic                   rd_zero_r, rd_zero_nxt;
  logic [SLOTS-1:0][7:0]  src_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r;
  logic                   emit;
  logic                   pg_last;
  logic                   wr_in_range;
  logic [5:0]             gl_load;
  logic [1:0]             col_off;
  logic [8:0]             col;

  assign pg_last     = (pg_r == PG_W'(PAGE_COUNT - 1));
  assign wr_in_range = (5'(in_data.page) < 5'(PAGE_COUNT)) &&
                       (9'(in_data.column) < 9'(COLUMN_COUNT));
  assign gl_load     = (grids_left_r == 6'd0) ? 6'(GRID_COUNT) : grids_left_r;
  // Odd grids walk their three columns downward
  assign col_off     = grid_r[0] ? (2'd2 - slot_r) : slot_r;
  assign col         = 9'(grid_r) * 9'd3 + 9'(col_off);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    grids_left_nxt = grids_left_r;
    grid_nxt       = grid_r;
    start_nxt      = start_r;
    pg_nxt         = pg_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    rd_valid_nxt   = 1'b0;
    rd_slot_nxt    = rd_slot_r;
    rd_zero_nxt    = rd_zero_r;
    mem_req        = '0;
    emit           = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        // Sweep zeros through the store
        mem_req.we    = 1'b1;
        mem_req.waddr = MEM_AW_MAX'(clr_r);
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.op == OP_WRITE) begin
            mem_req.we    = wr_in_range;
            mem_req.waddr = MEM_AW_MAX'(int'(in_data.page) * COLUMN_COUNT +
                                        int'(in_data.column));
            mem_req.wdata = in_data.pixels;
          end else begin
            // Reload the grid countdown on wrap and start the first page
            start_nxt      = (grids_left_r == 6'd0);
            grid_nxt       = gl_load - 6'd1;
            grids_left_nxt = gl_load - 6'd1;
            pg_nxt         = '0;
            slot_nxt       = 2'd0;
            state_nxt      = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        // Issue one column read per cycle
        mem_req.raddr = MEM_AW_MAX'(int'(pg_r) * COLUMN_COUNT + int'(col));
        rd_valid_nxt  = 1'b1;
        rd_slot_nxt   = slot_r;
        rd_zero_nxt   = (col >= 9'(COLUMN_COUNT));
        if (slot_r == 2'(SLOTS - 1)) begin
          slot_nxt  = 2'd0;
          state_nxt = S_LAND;
        end else begin
          slot_nxt = slot_r + 2'd1;
        end
      end
      S_LAND: begin
        // Let the last column read land
        idx_nxt   = 3'd0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          emit = 1'b1;
          if (idx_r == 3'(BYTES_PER_PAGE - 1)) begin
            idx_nxt = 3'd0;
            if (pg_last) begin
              state_nxt = S_IDLE;
            end else begin
              pg_nxt    = pg_r + 1'b1;
              state_nxt = S_FETCH;
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      grids_left_r <= 6'd0;
      rd_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      grids_left_r <= grids_left_nxt;
      rd_valid_r   <= rd_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    grid_r    <= grid_nxt;
    start_r   <= start_nxt;
    pg_r      <= pg_nxt;
    slot_r    <= slot_nxt;
    idx_r     <= idx_nxt;
    rd_slot_r <= rd_slot_nxt;
    rd_zero_r <= rd_zero_nxt;
    if (rd_valid_r) begin
      src_r[rd_slot_r] <= rd_zero_r ? 8'd0 : mem_rd_data;
    end
    if (emit) begin
      out_data_r.out_byte    <= pack_beat(src_r, idx_r, grid_r[0]);
      out_data_r.grid_number <= grid_r;
      out_data_r.frame_start <= start_r;
      out_data_r.last        <= pg_last && (idx_r == 3'(BYTES_PER_PAGE - 1));
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/vfd_grid_scan_remapper.sv =====
// vfd_grid_scan_remapper: top level, frame memory plus scan sequencer.
// Depends on vgsr_pkg, vgsr_frame_mem and vgsr_scan_seq.
//
//   channel | ports                          | beat
//   --------+--------------------------------+-----------------------------------
//   input   | in_valid, in_ready, in_data    | write (page, column, pixels) or tick
//   result  | out_valid, out_ready, out_data | shift byte, grid, frame_start, last
//
// A write beat is taken in S_IDLE and goes straight to the write port. A tick
// is accepted, then per page three column reads go on the one read port, a
// landing step (S_LAND) lets the last read land, then six bytes are emitted.
// After reset a sweep writes zeros to all PAGE_COUNT * COLUMN_COUNT (1024)
// frame store addresses; in_ready stays low through it.
// A stalled result output holds the emit loop; the final byte of a tick may
// wait in the output register while the next beat is taken.
module vfd_grid_scan_remapper import vgsr_pkg::*; #(
  parameter int GRID_COUNT   = 43,
  parameter int PAGE_COUNT   = 8,
  parameter int COLUMN_COUNT = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int DEPTH  = PAGE_COUNT * COLUMN_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);

  mem_req_t   mem_req;
  logic [7:0] mem_rd_data;

  vgsr_frame_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  vgsr_scan_seq #(
    .GRID_COUNT   (GRID_COUNT),
    .PAGE_COUNT   (PAGE_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

endmodule

// ===== hdl/vgsr_checker.sv =====
// vgsr_checker: port-level assertions for the grid scan remapper, bound to
// the top level. Depends on vgsr_pkg.
module vgsr_checker import vgsr_pkg::*; #(
  parameter int GRID_COUNT = 43
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Grid numbers stay inside the scan range
  a_grid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.grid_number < 6'(GRID_COUNT))
    else $error("grid number out of range");

  // The first grid after a wrap is the top grid
  a_start_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_start |->
      out_data.grid_number == 6'(GRID_COUNT - 1))
    else $error("frame start on a grid other than the top one");

  // A tick blocks further input while its bytes are built
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.op == OP_TICK |=> !in_ready)
    else $error("input accepted right after a tick");

endmodule

bind vfd_grid_scan_remapper vgsr_checker #(
  .GRID_COUNT (GRID_COUNT)
) u_vgsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== test/vfd_grid_scan_remapper_tb.sv =====
`timescale 1ns / 1ps
// vfd_grid_scan_remapper_tb: self-checking bench for the grid scan remapper.
// Drives write and tick beats; predicts shift bytes from a frame mirror or known values.
// Depends on vgsr_pkg and vfd_grid_scan_remapper.
module vfd_grid_scan_remapper_tb;
  import vgsr_pkg::*;

  localparam int GRIDS          = 43;
  localparam int PAGES          = 8;
  localparam int COLS           = 128;
  localparam int BYTES_PER_GRID = PAGES * BYTES_PER_PAGE;
  localparam int RANDOM_BEATS   = 500;
  localparam int TICK_PCT       = 35;

  typedef struct {
    in_item_t   beat;
    bit         known;
    logic [7:0] known_byte;
    logic [5:0] known_grid;
    logic       known_start;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Frame mirror and grid countdown of the predictor
  logic [7:0]  frame_mirror [PAGES][COLS];
  logic [5:0]  grids_pending;
  out_item_t   shift_q[$];
  script_row_t script[$];

  int sender_idle_pct   = 23;
  int receiver_idle_pct = 53;
  bit failed = 1'b0;

  vfd_grid_scan_remapper #(
    .GRID_COUNT  (GRIDS),
    .PAGE_COUNT  (PAGES),
    .COLUMN_COUNT(COLS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Compare each result beat with the oldest predicted shift byte
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (shift_q.size() == 0) begin
        $error("result beat with nothing predicted: %0h", out_data);
        failed = 1'b1;
      end else begin
        want = shift_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
          failed = 1'b1;
        end
        if (out_data.grid_number !== want.grid_number) begin
          $error("grid_number: expected %0d, got %0d", want.grid_number,
                 out_data.grid_number);
          failed = 1'b1;
        end
        if (out_data.frame_start !== want.frame_start) begin
          $error("frame_start: expected %0b, got %0b", want.frame_start,
                 out_data.frame_start);
          failed = 1'b1;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Apply one beat to the mirror; for a tick, build the 48 shift bytes of the grid
  task automatic predict_beat(input in_item_t item, input bit queue_it);
    logic [7:0] src [3];
    logic [23:0] pix;
    logic [5:0] grid;
    logic start;
    out_item_t r;
    int odd;
    int col;
    int n;
    if (item.op == OP_WRITE) begin
      if (item.page < PAGES && item.column < COLS) begin
        frame_mirror[item.page][item.column] = item.pixels;
      end
      return;
    end
    start = 1'b0;
    if (grids_pending == 6'd0) begin
      grids_pending = 6'(GRIDS);
      start = 1'b1;
    end
    grid = grids_pending - 6'd1;
    odd = int'(grid[0]);
    n = 0;
    for (int pg = 0; pg < PAGES; pg++) begin
      // Odd grids read their three columns right to left; past the store reads zero
      for (int s = 0; s < 3; s++) begin
        col = (odd != 0) ? int'(grid) * 3 + 2 - s : int'(grid) * 3 + s;
        src[s] = (col < COLS) ? frame_mirror[pg][col] : 8'h00;
      end
      for (int row = 0; row < 8; row++) begin
        for (int s = 0; s < 3; s++) begin
          pix[row * 3 + s] = src[s][row];
        end
      end
      for (int k = 0; k < BYTES_PER_PAGE; k++) begin
        r.out_byte = '0;
        for (int q = 0; q < 4; q++) begin
          r.out_byte[2 * q + odd] = pix[4 * k + q];
        end
        r.grid_number = grid;
        r.frame_start = start;
        r.last        = (n == BYTES_PER_GRID - 1);
        n++;
        if (queue_it) begin
          shift_q.push_back(r);
        end
      end
    end
    grids_pending = grids_pending - 6'd1;
  endtask

  // Offer one beat at a falling edge and hold it until the block takes it
  task automatic issue_beat(input script_row_t row);
    out_item_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row.beat;
    do @(posedge clk); while (!in_ready);
    predict_beat(row.beat, !row.known);
    if (row.known) begin
      for (int n = 0; n < BYTES_PER_GRID; n++) begin
        r.out_byte    = row.known_byte;
        r.grid_number = row.known_grid;
        r.frame_start = row.known_start;
        r.last        = (n == BYTES_PER_GRID - 1);
        shift_q.push_back(r);
      end
    end
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted byte has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (shift_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  function automatic script_row_t beat_row(input logic op, input logic [2:0] page,
                                           input logic [6:0] column,
                                           input logic [7:0] pixels);
    script_row_t row;
    row.beat.op     = op;
    row.beat.page   = page;
    row.beat.column = column;
    row.beat.pixels = pixels;
    row.known       = 1'b0;
    row.known_byte  = '0;
    row.known_grid  = '0;
    row.known_start = 1'b0;
    return row;
  endfunction

  initial begin
    script_row_t row;
    int col;
    int upcoming;

    for (int p = 0; p < PAGES; p++) begin
      for (int c = 0; c < COLS; c++) begin
        frame_mirror[p][c] = 8'h00;
      end
    end
    grids_pending = '0;

    // Empty store: the first grid (with the column past the store) and the next are zero
    row = beat_row(OP_TICK, 3'd0, 7'd0, 8'h00);
    row.known = 1'b1;
    row.known_grid = 6'd42;
    row.known_start = 1'b1;
    script.push_back(row);
    row = beat_row(OP_TICK, 3'd7, 7'd127, 8'hFF);
    row.known = 1'b1;
    row.known_grid = 6'd41;
    script.push_back(row);
    // Corners of the store, then the columns of the next even and odd grids
    script.push_back(beat_row(OP_WRITE, 3'd0, 7'd0,   8'hFF));
    script.push_back(beat_row(OP_WRITE, 3'd7, 7'd127, 8'hFF));
    script.push_back(beat_row(OP_WRITE, 3'd7, 7'd0,   8'h80));
    script.push_back(beat_row(OP_WRITE, 3'd0, 7'd127, 8'h01));
    script.push_back(beat_row(OP_WRITE, 3'd3, 7'd120, 8'hA5));
    script.push_back(beat_row(OP_WRITE, 3'd3, 7'd121, 8'hFF));
    script.push_back(beat_row(OP_WRITE, 3'd3, 7'd122, 8'h5A));
    script.push_back(beat_row(OP_WRITE, 3'd5, 7'd119, 8'hFF));
    script.push_back(beat_row(OP_WRITE, 3'd5, 7'd117, 8'h0F));
    script.push_back(beat_row(OP_WRITE, 3'd6, 7'd118, 8'hF0));
    script.push_back(beat_row(OP_TICK,  3'd0, 7'd0,   8'h00));
    script.push_back(beat_row(OP_TICK,  3'd5, 7'd85,  8'hAA));
    script.push_back(beat_row(OP_WRITE, 3'd2, 7'd126, 8'hFF));
    script.push_back(beat_row(OP_WRITE, 3'd4, 7'd114, 8'h55));
    script.push_back(beat_row(OP_WRITE, 3'd1, 7'd116, 8'hC3));
    script.push_back(beat_row(OP_TICK,  3'd0, 7'd0,   8'h00));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      issue_beat(script[i]);
    end
    hold_until_drained();

    // Random beats; writes lean toward the columns of the next grid to be scanned
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 3) begin
        sender_idle_pct   = 53;
        receiver_idle_pct = 23;
        hold_until_drained();
      end
      if (i == 2 * RANDOM_BEATS / 3) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_until_drained();
      end
      row = beat_row($urandom_range(99) < TICK_PCT ? OP_TICK : OP_WRITE,
                     3'($urandom), 7'($urandom), 8'($urandom));
      case ($urandom_range(9))
        0: row.beat.pixels = 8'h00;
        1: row.beat.pixels = 8'hFF;
        default: ;
      endcase
      if (row.beat.op == OP_WRITE && $urandom_range(1) == 1) begin
        upcoming = (grids_pending == 0) ? GRIDS - 1 : int'(grids_pending) - 1;
        col = upcoming * 3 + int'($urandom_range(2));
        if (col < COLS) begin
          row.beat.column = 7'(col);
        end
      end
      issue_beat(row);
    end
    in_valid <= 1'b0;

    // Drain, then give trailing beats time to show up
    while (shift_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (!failed) begin
      $display("vfd_grid_scan_remapper_tb OK");
    end else begin
      $display("vfd_grid_scan_remapper_tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("vfd_grid_scan_remapper_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/vgsr_pkg.sv
hdl/vgsr_frame_mem.sv
hdl/vgsr_scan_seq.sv
hdl/vfd_grid_scan_remapper.sv
hdl/vgsr_checker.sv
test/vfd_grid_scan_remapper_tb.sv
